>>> rtl/mtf_pkg.sv
// Package for the move-to-front identifier stack.
// Operation and status codes, and the flag bundle from the compare unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

	// operation codes on the request word
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_GET    = 2'd2;

	// status codes on the response word
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// flags from the shared compare unit to the sequencer
	typedef struct packed {
		logic hit;      // entry read back equals the id being searched
		logic at_end;   // walk index has reached the entry count
		logic last;     // walk index is on the bottom entry or beyond
		logic at_top;   // walk index is zero
		logic full;     // every slot is occupied
		logic pos_ok;   // requested depth holds an entry
	} mtf_flags_t;

endpackage

`default_nettype wire

>>> rtl/mtf_if.sv
// Handshake interfaces for the move-to-front identifier stack.
// Request and response channels, valid/ready with payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mtf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] window_id;
	logic [4:0] position;

	modport source (output valid, output op, output window_id, output position, input ready);
	modport sink   (input valid, input op, input window_id, input position, output ready);
endinterface

interface mtf_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       found;
	logic [7:0] result_id;
	logic [4:0] entry_count;

	modport source (output valid, output status, output found, output result_id,
		output entry_count, input ready);
	modport sink   (input valid, input status, input found, input result_id,
		input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/mtf_cmp_unit.sv
// Shared compare unit of the move-to-front stack: id match and index tests.
// Used by the sequencer on every step of a walk. Depends on mtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtf_cmp_unit import mtf_pkg::*; #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 8,
	localparam int CW     = $clog2(DEPTH + 1)
) (
	input  wire logic [CW-1:0]      idx,
	input  wire logic [CW-1:0]      count,
	input  wire logic [ID_BITS-1:0] rdata,
	input  wire logic [ID_BITS-1:0] id,
	input  wire logic [4:0]         position,
	output mtf_flags_t              flags
);

	logic [CW:0] idx_inc;

	assign idx_inc = {1'b0, idx} + (CW+1)'(1);

	// all tests are narrow compares on the walk index and the read word
	always_comb begin
		flags.hit    = (rdata == id);
		flags.at_end = (idx == count);
		flags.last   = (idx_inc >= {1'b0, count});
		flags.at_top = (idx == '0);
		flags.full   = (32'(count) == DEPTH);
		flags.pos_ok = (32'(position) < 32'(count));
	end

endmodule

`default_nettype wire

>>> rtl/move_to_front_id_stack.sv
// Move-to-front identifier stack: sequencer, entry memory and response register.
// Depends on mtf_pkg, mtf_if (mtf_req_if, mtf_rsp_if) and mtf_cmp_unit.
//
//   channel | dir | payload                                   | handshake
//   req     | in  | op, window_id, position                   | valid/ready
//   rsp     | out | status, found, result_id, entry_count     | valid/ready
//
// One word at a time: req.ready is high only while idle. A push or delete walks
// the memory through its single read port: a read state and a compare state per entry
// searched, and a read state and a write state per entry moved.
// A get reads its entry in S_GET; it skips that state when the depth holds no entry.
// Reset clears the sequencer and the entry count; the memory needs no clearing.
// The response holds until taken; a stall on rsp holds off the next request.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_id_stack import mtf_pkg::*; #(
	parameter int DEPTH   = 16,
	parameter int ID_BITS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mtf_req_if.sink    req,
	mtf_rsp_if.source  rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// sequencer state codes
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SCAN_RD  = 4'd1;
	localparam logic [3:0] S_SCAN_CMP = 4'd2;
	localparam logic [3:0] S_DOWN_RD  = 4'd3;
	localparam logic [3:0] S_DOWN_WR  = 4'd4;
	localparam logic [3:0] S_UP_RD    = 4'd5;
	localparam logic [3:0] S_UP_WR    = 4'd6;
	localparam logic [3:0] S_GET      = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]         state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [1:0]         op_q;
	logic [ID_BITS-1:0] id_q;
	logic               grow_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [ID_BITS-1:0] rid_q;

	logic [ID_BITS-1:0] mem [DEPTH];
	logic [ID_BITS-1:0] rdata_q;
	logic               mem_re;
	logic               mem_we;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic [ID_BITS-1:0] wdata;

	logic [31:0]        wid_ext;
	logic [ID_BITS-1:0] id_in;
	logic [CW-1:0]      idx_dec;
	logic [CW-1:0]      idx_inc;
	logic               accept;
	mtf_flags_t         flags;

	// incoming id kept in its low ID_BITS bits
	assign wid_ext = 32'(req.window_id);
	assign id_in   = wid_ext[ID_BITS-1:0];
	assign idx_dec = idx_q - CW'(1);
	assign idx_inc = idx_q + CW'(1);
	assign accept  = req.valid && req.ready;

	// shared compare unit
	mtf_cmp_unit #(
		.DEPTH   (DEPTH),
		.ID_BITS (ID_BITS)
	) u_cmp (
		.idx      (idx_q),
		.count    (count_q),
		.rdata    (rdata_q),
		.id       (id_q),
		.position (req.position),
		.flags    (flags)
	);

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_we = 1'b0;
		raddr  = idx_q[AW-1:0];
		waddr  = idx_q[AW-1:0];
		wdata  = rdata_q;
		case (state_q)
			S_IDLE: begin
				raddr  = AW'(req.position);
				mem_re = accept && (req.op == OP_GET) && flags.pos_ok;
			end
			S_SCAN_RD: begin
				mem_re = !flags.at_end;
			end
			S_DOWN_RD: begin
				raddr = idx_dec[AW-1:0];
				if (flags.at_top) begin
					mem_we = 1'b1;
					wdata  = id_q;
				end else begin
					mem_re = 1'b1;
				end
			end
			S_DOWN_WR: mem_we = 1'b1;
			S_UP_RD: begin
				raddr  = idx_inc[AW-1:0];
				mem_re = !flags.last;
			end
			S_UP_WR: mem_we = 1'b1;
			default: ;
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	// sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.op)
							OP_PUSH, OP_DELETE: state_q <= S_SCAN_RD;
							OP_GET:             state_q <= flags.pos_ok ? S_GET : S_DONE;
							default:            state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN_RD: begin
					if (!flags.at_end)
						state_q <= S_SCAN_CMP;
					else if (op_q == OP_PUSH && !flags.full)
						state_q <= S_DOWN_RD;
					else
						state_q <= S_DONE;
				end
				S_SCAN_CMP: begin
					if (!flags.hit)
						state_q <= S_SCAN_RD;
					else if (op_q == OP_PUSH)
						state_q <= S_DOWN_RD;
					else
						state_q <= S_UP_RD;
				end
				S_DOWN_RD: begin
					if (flags.at_top) begin
						state_q <= S_DONE;
						if (grow_q)
							count_q <= count_q + CW'(1);
					end else begin
						state_q <= S_DOWN_WR;
					end
				end
				S_DOWN_WR: state_q <= S_DOWN_RD;
				S_UP_RD: begin
					if (flags.last) begin
						state_q <= S_DONE;
						count_q <= count_q - CW'(1);
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: state_q <= S_UP_RD;
				S_GET:   state_q <= S_DONE;
				S_DONE: begin
					if (rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk index, captured request and response fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= req.op;
					id_q     <= id_in;
					idx_q    <= '0;
					grow_q   <= 1'b0;
					found_q  <= 1'b0;
					rid_q    <= '0;
					status_q <= (req.op == OP_GET && !flags.pos_ok) ? ST_EMPTY : ST_OK;
				end
			end
			S_SCAN_RD: begin
				// id absent: a push either grows the stack or is refused
				if (flags.at_end && op_q == OP_PUSH) begin
					if (flags.full)
						status_q <= ST_FULL;
					else
						grow_q <= 1'b1;
				end
			end
			S_SCAN_CMP: begin
				if (!flags.hit)
					idx_q <= idx_inc;
			end
			S_DOWN_WR: idx_q <= idx_dec;
			S_UP_WR:   idx_q <= idx_inc;
			S_GET: begin
				found_q <= 1'b1;
				rid_q   <= rdata_q;
			end
			default: ;
		endcase
	end

	// channel outputs
	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = (state_q == S_DONE);
	assign rsp.status      = status_q;
	assign rsp.found       = found_q;
	assign rsp.result_id   = 8'(rid_q);
	assign rsp.entry_count = 5'(count_q);

endmodule

`default_nettype wire

>>> rtl/mtf_chk.sv
// Port-level checker for the move-to-front identifier stack, with its bind.
// Depends on mtf_pkg and move_to_front_id_stack.
`timescale 1ns / 1ps
`default_nettype none

module mtf_chk import mtf_pkg::*; #(
	parameter int DEPTH = 16
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] status,
	input wire logic       found,
	input wire logic [7:0] result_id,
	input wire logic [4:0] entry_count
);

	// one word in flight: no new request while a response waits
	a_no_req_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a response is pending");

	// an accepted word makes the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("block still ready right after accepting a word");

	// a found entry always comes with an ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && found) |-> (status == ST_OK))
		else $error("found set with a non-ok status");

	// no identifier shown unless found
	a_rid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !found) |-> (result_id == 8'd0))
		else $error("result_id non-zero without a find");

	// entry count stays within the stack depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && DEPTH < 32) |-> (32'(entry_count) <= DEPTH))
		else $error("entry_count beyond stack depth");

endmodule

bind move_to_front_id_stack mtf_chk #(
	.DEPTH (DEPTH)
) u_mtf_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.found       (rsp.found),
	.result_id   (rsp.result_id),
	.entry_count (rsp.entry_count)
);

`default_nettype wire

>>> sim/move_to_front_id_stack_tb.sv
// Testbench for move_to_front_id_stack: directed and random request words,
// with a scoreboard class that keeps its own copy of the id stack.
// Depends on rtl/mtf_pkg.sv, rtl/mtf_if.sv and the block's RTL.
`timescale 1ns / 1ps

module move_to_front_id_stack_tb import mtf_pkg::*;;

	localparam int         STACK_DEPTH = 16;
	localparam int         LONG_HOLD   = 200;   // receiver hold-off under pressure
	localparam int         TAIL_CYCLES = 80;    // idle tail, longer than the worst walk
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [7:0] result_id;
		logic [4:0] entry_count;
	} stack_rsp_t;

	// Scoreboard: shadow stack of ids and the queue of expected response words
	class mtf_scoreboard;
		logic [7:0]  stack_ids [STACK_DEPTH];
		int unsigned depth_used;
		stack_rsp_t  expected_q [$];
		int unsigned errors;
		int unsigned checked;
		int unsigned refused_pushes;
		int unsigned empty_gets;
		int unsigned hits;

		function new();
			foreach (stack_ids[i])
				stack_ids[i] = '0;
			depth_used = 0;
		endfunction

		function int locate(logic [7:0] id);
			int i;
			for (i = 0; i < depth_used; i++)
				if (stack_ids[i] == id)
					return i;
			return -1;
		endfunction

		// close the gap left by the entry at 'at'
		function void drop_at(int at);
			int i;
			for (i = at; i + 1 < depth_used; i++)
				stack_ids[i] = stack_ids[i + 1];
			depth_used--;
		endfunction

		// work out the response to one accepted request word
		function void note_request(logic [1:0] op, logic [7:0] id, logic [4:0] pos);
			stack_rsp_t r;
			int         at;
			int         i;
			r = '0;
			case (op)
				OP_PUSH: begin
					// id already on top: nothing moves
					if (!(depth_used > 0 && stack_ids[0] == id)) begin
						at = locate(id);
						if (at >= 0)
							drop_at(at);
						if (depth_used >= STACK_DEPTH) begin
							r.status = ST_FULL;
							refused_pushes++;
						end else begin
							for (i = depth_used; i > 0; i--)
								stack_ids[i] = stack_ids[i - 1];
							stack_ids[0] = id;
							depth_used++;
						end
					end
				end
				OP_DELETE: begin
					at = locate(id);
					if (at >= 0)
						drop_at(at);
				end
				OP_GET: begin
					if (pos < depth_used) begin
						r.found     = 1'b1;
						r.result_id = stack_ids[pos];
						hits++;
					end else begin
						r.status = ST_EMPTY;
						empty_gets++;
					end
				end
				default: ;
			endcase
			r.entry_count = depth_used[4:0];
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			if (errors < 100)
				$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
			errors++;
		endtask

		// compare one accepted response word with the oldest expectation
		task check_response(logic [1:0] status, logic found, logic [7:0] result_id,
			logic [4:0] entry_count);
			stack_rsp_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected response word", 1, 0);
			end else begin
				want = expected_q.pop_front();
				checked++;
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (result_id !== want.result_id)
					report_mismatch("result_id", result_id, want.result_id);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", entry_count, want.entry_count);
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          hold_start;
	int            src_idle_pct;
	int            snk_stall_pct;
	int unsigned   words_sent;
	mtf_scoreboard sb = new();

	mtf_req_if req_ch ();
	mtf_rsp_if rsp_ch ();

	move_to_front_id_stack #(
		.DEPTH   (STACK_DEPTH),
		.ID_BITS (8)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watch both channels and feed the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.op, req_ch.window_id, req_ch.position);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.result_id,
					rsp_ch.entry_count);
		end
	end

	// receiver: random stalls, or a long hold-off counted here
	initial begin : response_side
		int stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_start) begin
				stall_left = LONG_HOLD;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// offer one request word and return at the edge that takes it
	task automatic send_word(logic [1:0] op, logic [7:0] id, logic [4:0] pos);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.window_id <= id;
		req_ch.position  <= pos;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	// stop offering and wait until every expected word has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// random words; ids mostly from a small pool so the stack fills and hits
	task automatic run_phase(int n_words, int src_pct, int snk_pct, logic [7:0] id_base,
		int pool);
		logic [1:0] op;
		logic [7:0] id;
		logic [4:0] pos;
		int         pick;
		src_idle_pct = src_pct;
		snk_stall_pct <= snk_pct;
		repeat (n_words) begin
			pick = $urandom_range(99);
			if (pick < 50)
				op = OP_PUSH;
			else if (pick < 68)
				op = OP_DELETE;
			else if (pick < 95)
				op = OP_GET;
			else
				op = OP_UNUSED;
			if ($urandom_range(11) == 0)
				id = 8'($urandom_range(255));
			else
				id = id_base + 8'($urandom_range(pool - 1));
			if ($urandom_range(7) == 0)
				pos = 5'($urandom_range(31));
			else
				pos = 5'($urandom_range(17));
			send_word(op, id, pos);
		end
		wait_drained();
	endtask

	// main sequence
	initial begin : stimulus
		int k;
		arst_n           = 1'b0;
		hold_start       = 1'b0;
		src_idle_pct     = 0;
		snk_stall_pct    = 0;
		words_sent       = 0;
		req_ch.valid     = 1'b0;
		req_ch.op        = OP_PUSH;
		req_ch.window_id = '0;
		req_ch.position  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack: get past the end, unused op, delete of an absent id
		send_word(OP_GET, 8'd0, 5'd31);
		send_word(OP_UNUSED, 8'hff, 5'd31);
		send_word(OP_DELETE, 8'd5, 5'd0);
		// id 0 and id 255, push of the top id, move of a deeper id to the top
		send_word(OP_PUSH, 8'd0, 5'd0);
		send_word(OP_PUSH, 8'hff, 5'd0);
		send_word(OP_PUSH, 8'hff, 5'd0);
		send_word(OP_PUSH, 8'd0, 5'd0);
		send_word(OP_GET, 8'd0, 5'd1);
		send_word(OP_DELETE, 8'd0, 5'd0);
		// fill up, then push an absent id and a present one onto the full stack
		for (k = 1; k < STACK_DEPTH; k++)
			send_word(OP_PUSH, 8'(k), 5'd0);
		send_word(OP_PUSH, 8'd200, 5'd0);
		send_word(OP_PUSH, 8'hff, 5'd0);
		send_word(OP_GET, 8'd0, 5'd15);
		send_word(OP_GET, 8'd0, 5'd16);
		wait_drained();

		run_phase(290, 0, 0, 8'd0, 20);
		run_phase(285, 75, 0, 8'd200, 18);

		// receiver holds off while words keep coming, so the input stalls
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		run_phase(30, 0, 0, 8'd60, 20);

		run_phase(285, 0, 75, 8'd120, 24);
		run_phase(290, 22, 22, 8'd250, 20);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d request words over five idling phases; %0d responses checked.",
			words_sent, sb.checked);
		$display("Full-stack refusals %0d, empty gets %0d, successful gets %0d.",
			sb.refused_pushes, sb.empty_gets, sb.hits);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// overall time limit
	initial begin : watchdog
		#5_000_000;
		$display("Timeout waiting for the block");
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> move_to_front_id_stack.f
rtl/mtf_pkg.sv
rtl/mtf_if.sv
rtl/mtf_cmp_unit.sv
rtl/move_to_front_id_stack.sv
rtl/mtf_chk.sv
sim/move_to_front_id_stack_tb.sv
